FILE: sv/lpbp_pkg.sv
// Shared types, constants and the item structs of the LRU page buffer pool.
// Used by the tag cells, the recency cells and the top level.
`default_nettype none
package lpbp_pkg;

  localparam int FRAMES       = 8;
  localparam int PAGE_ID_BITS = 16;
  localparam int FRAME_BITS   = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // Register indexes (paddr[2] selects the register)
  localparam logic REG_WRITEBACK_ENABLE = 1'b0;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic [PAGE_ID_BITS-1:0] page_t;
  typedef logic [FRAME_BITS-1:0]   frame_t;

  typedef struct packed {
    logic        command;
    logic [15:0] page_id;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  frame;
    logic        evict_valid;
    logic [15:0] evicted_page;
    logic        writeback_needed;
  } res_t;

  // Update to one tag cell
  typedef struct packed {
    logic  load;       // take a new page on a miss
    logic  set_dirty;  // write hit
    logic  dirty_val;  // dirty mark for a loaded page
    page_t page;
  } tag_ctrl_t;

  // Status of one tag cell
  typedef struct packed {
    logic  match;
    logic  valid;
    logic  dirty;
    page_t page;
  } tag_stat_t;

endpackage
`default_nettype wire

FILE: sv/lpbp_tag_cell.sv
// One frame of the directory: page tag, valid and dirty marks, tag compare.
// Depends on lpbp_pkg.
`default_nettype none
module lpbp_tag_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lpbp_pkg::page_t    probe,
  input  wire lpbp_pkg::tag_ctrl_t ctrl,
  output lpbp_pkg::tag_stat_t     stat
);
  import lpbp_pkg::*;

  page_t page;
  logic  valid;
  logic  dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      dirty <= 1'b0;
    end else if (ctrl.load) begin
      valid <= 1'b1;
      dirty <= ctrl.dirty_val;
    end else if (ctrl.set_dirty) begin
      dirty <= 1'b1;
    end
  end

  // tag carries no reset: it is only looked at while valid is set
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      page <= ctrl.page;
    end
  end

  assign stat.match = valid && (page == probe);
  assign stat.valid = valid;
  assign stat.dirty = dirty;
  assign stat.page  = page;

endmodule
`default_nettype wire

FILE: sv/lpbp_order_cell.sv
// One slot of the recency chain: holds a frame number and shifts in its
// upper neighbour's value when it or a lower slot holds the touched frame.
// Depends on lpbp_pkg.
`default_nettype none
module lpbp_order_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lpbp_pkg::frame_t init_frame,
  input  wire logic             advance,
  input  wire lpbp_pkg::frame_t touched,
  input  wire lpbp_pkg::frame_t upper,
  input  wire logic             chain_in,
  output logic                  chain_out,
  output lpbp_pkg::frame_t      slot
);
  import lpbp_pkg::*;

  assign chain_out = chain_in || (slot == touched);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= init_frame;
    end else if (advance && chain_out) begin
      slot <= upper;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lru_page_buffer_pool.sv
// Top level of the LRU page buffer pool: tag cells, recency chain, APB
// register and result register. Depends on lpbp_pkg, lpbp_tag_cell and
// lpbp_order_cell.
//
//   channel   handshake              payload
//   access    start && !busy         req    (command, page_id)
//   result    done, one cycle        result (hit, frame, evict_valid, ...)
//   config    psel&penable&pwrite    paddr, pwdata / prdata
//
// One item per cycle: the item is looked up against every tag cell, the
// frame is chosen and the recency chain advances at the accepting edge.
// The result appears on the next cycle with done high for that cycle only.
// busy stays low; the receiver cannot stall, so nothing is held back.
// Reset (rst, synchronous) clears valid and dirty marks, sets the recency
// chain to frames in order and enables write-back.
`default_nettype none
module lru_page_buffer_pool (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire lpbp_pkg::req_t                    req,
  output logic                                   done,
  output lpbp_pkg::res_t                         result,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lpbp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [lpbp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lpbp_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                   pready
);
  import lpbp_pkg::*;

  logic        wb_enable;
  logic        accept;
  logic [31:0] page_wide;
  page_t       probe;

  tag_ctrl_t   tag_ctrl [FRAMES];
  tag_stat_t   tag_stat [FRAMES];
  frame_t      order    [FRAMES];
  logic [FRAMES:0] chain;

  logic [FRAMES-1:0] valid_vec;
  logic        any_hit;
  frame_t      hit_frame;
  logic        any_free;
  frame_t      free_frame;
  frame_t      sel_frame;
  logic        evicting;
  logic [31:0] frame_wide;
  logic [31:0] evict_wide;
  res_t        res_next;

  // ---- configuration port ----
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_enable <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WRITEBACK_ENABLE)) begin
      wb_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WRITEBACK_ENABLE) begin
      prdata[0] = wb_enable;
    end
  end

  // ---- lookup ----
  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign page_wide = 32'(req.page_id);
  assign probe     = page_wide[PAGE_ID_BITS-1:0];

  always_comb begin
    any_hit    = 1'b0;
    hit_frame  = '0;
    any_free   = 1'b0;
    free_frame = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      valid_vec[k] = tag_stat[k].valid;
      if (tag_stat[k].match) begin
        any_hit   = 1'b1;
        hit_frame = FRAME_BITS'(k);
      end
      if (!tag_stat[k].valid) begin
        any_free   = 1'b1;
        free_frame = FRAME_BITS'(k);
      end
    end
  end

  assign evicting  = !any_hit && !any_free;
  assign sel_frame = any_hit ? hit_frame : (any_free ? free_frame : order[0]);

  always_comb begin
    for (int k = 0; k < FRAMES; k++) begin
      tag_ctrl[k].load      = accept && !any_hit && (sel_frame == FRAME_BITS'(k));
      tag_ctrl[k].set_dirty = accept && any_hit && (hit_frame == FRAME_BITS'(k))
                              && (req.command == CMD_WRITE);
      tag_ctrl[k].dirty_val = (req.command == CMD_WRITE);
      tag_ctrl[k].page      = probe;
    end
  end

  assign chain[0] = 1'b0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpbp_tag_cell u_tag (
      .clk   (clk),
      .rst   (rst),
      .probe (probe),
      .ctrl  (tag_ctrl[g]),
      .stat  (tag_stat[g])
    );

    // the top slot takes the touched frame, every other one its neighbour
    lpbp_order_cell u_order (
      .clk        (clk),
      .rst        (rst),
      .init_frame (FRAME_BITS'(g)),
      .advance    (accept),
      .touched    (sel_frame),
      .upper      ((g == FRAMES - 1) ? sel_frame : order[(g + 1) % FRAMES]),
      .chain_in   (chain[g]),
      .chain_out  (chain[g+1]),
      .slot       (order[g])
    );
  end

  // ---- result ----
  assign frame_wide = 32'(sel_frame);
  assign evict_wide = 32'(tag_stat[order[0]].page);

  always_comb begin
    res_next.hit              = any_hit;
    res_next.frame            = frame_wide[2:0];
    res_next.evict_valid      = evicting;
    res_next.evicted_page     = evicting ? evict_wide[15:0] : 16'd0;
    res_next.writeback_needed = evicting && tag_stat[order[0]].dirty && wb_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
  end

  // ---- checks ----
  logic [FRAMES-1:0] seen;

  always_comb begin
    seen = '0;
    for (int k = 0; k < FRAMES; k++) begin
      seen[order[k]] = 1'b1;
    end
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without an accepted item");

  a_order_is_permutation: assert property (@(posedge clk) disable iff (rst)
    &seen)
    else $error("recency chain lost a frame");

  a_evict_only_when_full: assert property (@(posedge clk) disable iff (rst)
    accept && evicting |=> done && result.evict_valid && $past(&valid_vec))
    else $error("eviction while a frame was free");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> !result.evict_valid && !result.writeback_needed)
    else $error("hit reported a displaced page");

  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    done && result.writeback_needed |-> result.evict_valid)
    else $error("write-back without eviction");

endmodule
`default_nettype wire
